// ===== rtl/mpfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfp_pkg
// Shared types and constants for the meter property frame parser.
// ----------------------------------------------------------------------------
package mpfp_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_BYTE0 = 8'h10;
    localparam logic [7:0] HDR_BYTE1 = 8'h81;

    // Property codes of interest
    localparam logic [7:0] EPC_UNIT    = 8'hE1;
    localparam logic [7:0] EPC_POWER   = 8'hE7;
    localparam logic [7:0] EPC_FWD_ENG = 8'hEA;
    localparam logic [7:0] EPC_REV_ENG = 8'hEB;

    // Minimum data lengths per property
    localparam logic [7:0] LEN_UNIT   = 8'd1;
    localparam logic [7:0] LEN_POWER  = 8'd4;
    localparam logic [7:0] LEN_ENERGY = 8'd11;

    // Energy record layout: date bytes first, then the count
    localparam logic [7:0] STAMP_BYTES = 8'd7;

    // Valid energy unit codes
    localparam logic [31:0] UNIT_TENTHS_MAX = 32'h04;
    localparam logic [31:0] UNIT_TENS_MIN   = 32'h0A;
    localparam logic [31:0] UNIT_TENS_MAX   = 32'h0D;

    // Result kinds
    localparam logic [2:0] KIND_UNIT    = 3'd0;
    localparam logic [2:0] KIND_POWER   = 3'd1;
    localparam logic [2:0] KIND_FWD_ENG = 3'd2;
    localparam logic [2:0] KIND_REV_ENG = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;

    // Frame classes
    localparam logic [1:0] CLASS_OTHER  = 2'd0;
    localparam logic [1:0] CLASS_POWER  = 2'd1;
    localparam logic [1:0] CLASS_ENERGY = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SOURCE_MATCH = 1'b0;
    localparam logic CFG_DEST_MATCH   = 1'b1;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = RQ_PTR_W + 1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] reading;
        logic [3:0]  unit_code;
        logic [15:0] stamp_year;
        logic [7:0]  stamp_month;
        logic [7:0]  stamp_day;
        logic [7:0]  stamp_hour;
        logic [7:0]  stamp_minute;
        logic [7:0]  stamp_second;
        logic [1:0]  frame_class;
    } result_t;

    // Up to two results per input beat, first one in slot first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/mpfp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// mpfp_result_fifo
// Small register queue for result beats: takes zero, one or two results per
// cycle and hands out one per cycle on a valid/ready port while head_ready is high.
// ----------------------------------------------------------------------------
module mpfp_result_fifo
    import mpfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output result_t head,
    output logic    head_valid,
    input  logic    head_ready
);

    result_t               slot_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic                  pop;

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign room       = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign pop        = head_valid && head_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            slot_reg[wr_ptr_reg + RQ_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ===== rtl/meter_property_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// meter_property_frame_parser_unit
// Byte-stream parser for meter property frames: checks header and object
// codes, walks the property list and reports unit, power and energy values.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on s_* and never stalls a frame in
// steady state: each byte is parsed in the cycle it is accepted, and the
// results it causes (at most two: a property result, then frame done on the
// last byte) land in a four-entry result queue that drives m_*. When the queue
// is empty, the first result of a byte is visible on m_* the cycle after the
// byte is taken; otherwise it waits behind the older results. The queue drains
// one result per cycle while m_ready is high, so s_ready drops only while
// fewer than two queue slots are free, which happens only while m_ready is
// held low: with m_ready high a two-result beat leaves at most two entries
// and the queue drains before the next one can arrive. Source and destination
// object codes come from two 24-bit match registers written over cfg_*; write
// them only while no frame is in flight.
// ----------------------------------------------------------------------------
module meter_property_frame_parser_unit
    import mpfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wr_data,

    // frame byte beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_reading,
    output logic [3:0]  m_unit_code,
    output logic [15:0] m_stamp_year,
    output logic [7:0]  m_stamp_month,
    output logic [7:0]  m_stamp_day,
    output logic [7:0]  m_stamp_hour,
    output logic [7:0]  m_stamp_minute,
    output logic [7:0]  m_stamp_second,
    output logic [1:0]  m_frame_class
);

    // Parser position: header bytes first, then property walk
    localparam logic [3:0] POS_EHD1  = 4'd0;
    localparam logic [3:0] POS_EHD2  = 4'd1;
    localparam logic [3:0] POS_SEOJ0 = 4'd4;
    localparam logic [3:0] POS_DEOJ2 = 4'd9;
    localparam logic [3:0] POS_OPC   = 4'd11;
    localparam logic [3:0] POS_CODE  = 4'd12;
    localparam logic [3:0] POS_LEN   = 4'd13;
    localparam logic [3:0] POS_DATA  = 4'd14;
    localparam logic [3:0] POS_IDLE  = 4'd15;

    // match registers
    logic [23:0] src_match_reg;
    logic [23:0] dst_match_reg;

    // parse state
    logic [3:0]  pos_reg,        pos_next;
    logic        hdr_ok_reg,     hdr_ok_next;
    logic [47:0] obj_reg,        obj_next;
    logic [7:0]  props_left_reg, props_left_next;
    logic [7:0]  code_reg,       code_next;
    logic [7:0]  len_reg,        len_next;
    logic [7:0]  idx_reg,        idx_next;
    logic [31:0] data_reg,       data_next;
    logic [55:0] stamp_reg,      stamp_next;
    logic [3:0]  unit_reg,       unit_next;
    logic [1:0]  class_reg,      class_next;

    logic        beat;
    logic        finish;
    logic        need_ok;
    logic        prop_hit;
    logic        obj_ok;
    logic [8:0]  idx_plus;
    result_t     prop_res;
    result_t     done_res;
    push_t       push;
    logic        room;
    result_t     head;

    assign beat    = s_valid && s_ready;
    assign s_ready = room;

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_match_reg <= 24'h028801;
            dst_match_reg <= 24'h05FF01;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SOURCE_MATCH: src_match_reg <= cfg_wr_data;
                CFG_DEST_MATCH:   dst_match_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Per-byte parse step
    // ------------------------------------------------------------------------
    assign obj_ok   = hdr_ok_reg && (obj_reg[47:24] == src_match_reg)
                      && (obj_reg[23:0] == dst_match_reg);
    assign idx_plus = {1'b0, idx_reg} + 9'd1;

    // A property counts only if it carries at least the bytes it needs; a
    // zero-length one closes on its length byte and never counts
    always_comb begin
        case (code_reg)
            EPC_UNIT:                 need_ok = (len_reg >= LEN_UNIT);
            EPC_POWER:                need_ok = (len_reg >= LEN_POWER);
            EPC_FWD_ENG, EPC_REV_ENG: need_ok = (len_reg >= LEN_ENERGY);
            default:                  need_ok = 1'b0;
        endcase
    end

    always_comb begin
        pos_next        = pos_reg;
        hdr_ok_next     = hdr_ok_reg;
        obj_next        = obj_reg;
        props_left_next = props_left_reg;
        code_next       = code_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        data_next       = data_reg;
        stamp_next      = stamp_reg;
        unit_next       = unit_reg;
        class_next      = class_reg;
        finish          = 1'b0;
        prop_hit        = 1'b0;
        prop_res        = '0;
        done_res        = '0;
        push            = '0;

        if (beat) begin
            if (pos_reg < POS_CODE) begin
                // header: check marker bytes, collect object codes
                unique case (pos_reg) inside
                    POS_EHD1: hdr_ok_next = (s_data_byte == HDR_BYTE0);
                    POS_EHD2: begin
                        if (s_data_byte != HDR_BYTE1) begin
                            hdr_ok_next = 1'b0;
                        end
                    end
                    [POS_SEOJ0:POS_DEOJ2]: obj_next = {obj_reg[39:0], s_data_byte};
                    default: ;
                endcase
                if (pos_reg == POS_OPC) begin
                    props_left_next = s_data_byte;
                    pos_next = (obj_ok && s_data_byte != 8'd0) ? POS_CODE : POS_IDLE;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end else begin
                unique case (pos_reg)
                    POS_CODE: begin
                        code_next = s_data_byte;
                        pos_next  = POS_LEN;
                    end
                    POS_LEN: begin
                        len_next   = s_data_byte;
                        idx_next   = '0;
                        data_next  = '0;
                        stamp_next = '0;
                        if (s_data_byte == 8'd0) begin
                            finish = 1'b1;
                        end else begin
                            pos_next = POS_DATA;
                        end
                    end
                    POS_DATA: begin
                        // keep only the leading bytes each property needs
                        case (code_reg)
                            EPC_FWD_ENG, EPC_REV_ENG: begin
                                if (idx_reg < STAMP_BYTES) begin
                                    stamp_next = {stamp_reg[47:0], s_data_byte};
                                end else if (idx_reg < LEN_ENERGY) begin
                                    data_next = {data_reg[23:0], s_data_byte};
                                end
                            end
                            EPC_POWER: begin
                                if (idx_reg < LEN_POWER) begin
                                    data_next = {data_reg[23:0], s_data_byte};
                                end
                            end
                            EPC_UNIT: begin
                                if (idx_reg == 8'd0) begin
                                    data_next = {24'd0, s_data_byte};
                                end
                            end
                            default: ;
                        endcase
                        if (idx_plus >= {1'b0, len_reg}) begin
                            finish = 1'b1;
                        end else begin
                            idx_next = idx_plus[7:0];
                        end
                    end
                    default: ;  // idle: drop the byte
                endcase
            end

            // property complete: report it if it met its length, then advance to the next one
            if (finish) begin
                if (need_ok && pos_reg == POS_DATA) begin
                    prop_hit = 1'b1;
                    case (code_reg)
                        EPC_UNIT: begin
                            if (data_next <= UNIT_TENTHS_MAX
                                || (data_next >= UNIT_TENS_MIN
                                    && data_next <= UNIT_TENS_MAX)) begin
                                unit_next = data_next[3:0];
                            end
                            prop_res.kind = KIND_UNIT;
                        end
                        EPC_POWER: begin
                            class_next       = CLASS_POWER;
                            prop_res.kind    = KIND_POWER;
                            prop_res.reading = data_next;
                        end
                        default: begin
                            class_next            = CLASS_ENERGY;
                            prop_res.kind         = (code_reg == EPC_FWD_ENG)
                                                    ? KIND_FWD_ENG : KIND_REV_ENG;
                            prop_res.reading      = data_next;
                            prop_res.stamp_year   = stamp_next[55:40];
                            prop_res.stamp_month  = stamp_next[39:32];
                            prop_res.stamp_day    = stamp_next[31:24];
                            prop_res.stamp_hour   = stamp_next[23:16];
                            prop_res.stamp_minute = stamp_next[15:8];
                            prop_res.stamp_second = stamp_next[7:0];
                        end
                    endcase
                    prop_res.unit_code = unit_next;
                end
                props_left_next = props_left_reg - 8'd1;
                pos_next = (props_left_next == 8'd0) ? POS_IDLE : POS_CODE;
            end

            done_res.kind        = KIND_DONE;
            done_res.unit_code   = unit_next;
            done_res.frame_class = class_next;

            // queue results in order: property first, then frame done
            if (prop_hit) begin
                push.first = prop_res;
                push.second = done_res;
                push.count = s_last_byte ? 2'd2 : 2'd1;
            end else begin
                push.first = done_res;
                push.count = s_last_byte ? 2'd1 : 2'd0;
            end

            // frame over: clear parse state, keep the energy unit
            if (s_last_byte) begin
                pos_next        = POS_EHD1;
                hdr_ok_next     = 1'b0;
                obj_next        = '0;
                props_left_next = '0;
                code_next       = '0;
                len_next        = '0;
                idx_next        = '0;
                data_next       = '0;
                stamp_next      = '0;
                class_next      = CLASS_OTHER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_EHD1;
            hdr_ok_reg     <= 1'b0;
            obj_reg        <= '0;
            props_left_reg <= '0;
            code_reg       <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            data_reg       <= '0;
            stamp_reg      <= '0;
            unit_reg       <= '0;
            class_reg      <= CLASS_OTHER;
        end else begin
            pos_reg        <= pos_next;
            hdr_ok_reg     <= hdr_ok_next;
            obj_reg        <= obj_next;
            props_left_reg <= props_left_next;
            code_reg       <= code_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            data_reg       <= data_next;
            stamp_reg      <= stamp_next;
            unit_reg       <= unit_next;
            class_reg      <= class_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------------
    mpfp_result_fifo u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (room),
        .head       (head),
        .head_valid (m_valid),
        .head_ready (m_ready)
    );

    assign m_kind         = head.kind;
    assign m_reading      = head.reading;
    assign m_unit_code    = head.unit_code;
    assign m_stamp_year   = head.stamp_year;
    assign m_stamp_month  = head.stamp_month;
    assign m_stamp_day    = head.stamp_day;
    assign m_stamp_hour   = head.stamp_hour;
    assign m_stamp_minute = head.stamp_minute;
    assign m_stamp_second = head.stamp_second;
    assign m_frame_class  = head.frame_class;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A last byte always returns the parser to the first header byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte) |=> (pos_reg == POS_EHD1))
        else $error("parser not cleared after last byte");

    // While walking properties at least one property is still open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_CODE || pos_reg == POS_LEN || pos_reg == POS_DATA)
        |-> (props_left_reg != 8'd0))
        else $error("property walk with no properties left");

    // Inside property data the index never reaches the declared length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_DATA) |-> (idx_reg < len_reg))
        else $error("data index past property length");

endmodule
